// ===== hdl/liu2x_pkg.sv =====
// Shared constants, types and helpers of the two-times linear-interpolation upsampler.
package liu2x_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned RATE_W   = 17;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned STEP_W   = 17;
  localparam int unsigned QUOT_W   = 16;
  localparam int unsigned OCNT_W   = 17;
  localparam int unsigned IDX_W    = 2;

  localparam logic [LEN_W-1:0]  MIN_BLOCK = LEN_W'(4);
  localparam logic [LEN_W-1:0]  MAX_BLOCK = LEN_W'(32768);
  localparam logic [LEN_W-1:0]  BLOCK_LENGTH_RST = LEN_W'(1024);
  localparam logic [RATE_W-1:0] SOURCE_RATE_RST  = RATE_W'(16000);
  localparam logic [RATE_W-1:0] TARGET_RATE_RST  = RATE_W'(32000);
  localparam logic [STEP_W-1:0] STEP_RST =
      STEP_W'(((1024 - 2) * 65536) / (2 * 1024 - 2));

  localparam logic [IDX_W-1:0] REG_BLOCK_LENGTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_SOURCE_RATE  = 2'd1;
  localparam logic [IDX_W-1:0] REG_TARGET_RATE  = 2'd2;

  typedef struct packed {
    logic load_cur;
    logic emit;
    logic emit_last;
    logic advance;
    logic restart;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic more;
    logic at_last;
    logic out_free;
    logic div_busy;
  } sts_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (n < MIN_BLOCK) begin
      n = MIN_BLOCK;
    end
    if (n > MAX_BLOCK) begin
      n = MAX_BLOCK;
    end
    return n;
  endfunction

endpackage

// ===== hdl/liu2x_div.sv =====
// Restoring divider that works out the 16.16 phase step, one quotient bit per cycle.
module liu2x_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [liu2x_pkg::LEN_W-1:0]   len_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [liu2x_pkg::QUOT_W-1:0]  quot_o
);

  logic                          busy_q, busy_d;
  logic [3:0]                    cnt_q, cnt_d;
  logic [liu2x_pkg::LEN_W:0]     rem_q, rem_d;
  logic [liu2x_pkg::LEN_W:0]     div_q, div_d;
  logic [liu2x_pkg::QUOT_W-1:0]  quo_q, quo_d;
  logic [liu2x_pkg::LEN_W:0]     rem_sh;
  logic                          qbit;

  assign rem_sh = {rem_q[liu2x_pkg::LEN_W-1:0], 1'b0};
  assign qbit   = (rem_sh >= div_q);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, len_i} - 17'd2;
      div_d  = {len_i, 1'b0} - 17'd2;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = qbit ? (rem_sh - div_q) : rem_sh;
      quo_d = {quo_q[liu2x_pkg::QUOT_W-2:0], qbit};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && !start_i && (cnt_q == 4'd15);
  assign quot_o = quo_d;

endmodule

// ===== hdl/liu2x_dp.sv =====
// Datapath: configuration registers, phase accumulator, blend multiplier and output register.
module liu2x_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [liu2x_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [liu2x_pkg::RATE_W-1:0]    cfg_data_i,
  input  logic [liu2x_pkg::SAMPLE_W-1:0]  in_sample_i,
  input  logic                            out_stall_i,
  input  liu2x_pkg::cmd_t                 cmd_i,
  output liu2x_pkg::sts_t                 sts_o,
  output logic                            out_valid_o,
  output logic [liu2x_pkg::SAMPLE_W-1:0]  out_sample_o,
  output logic                            block_end_o
);

  logic [liu2x_pkg::LEN_W-1:0]    blen_q;
  logic [liu2x_pkg::RATE_W-1:0]   src_q, tgt_q;
  logic [liu2x_pkg::STEP_W-1:0]   step_q;
  logic [liu2x_pkg::PHASE_W-1:0]  phase_q;
  logic [liu2x_pkg::LEN_W-1:0]    in_cnt_q;
  logic [liu2x_pkg::OCNT_W-1:0]   out_cnt_q;
  logic [liu2x_pkg::SAMPLE_W-1:0] prev_q, cur_q;
  logic                           out_valid_q;
  logic [liu2x_pkg::SAMPLE_W-1:0] out_sample_q;
  logic                           block_end_q;

  logic                           len_wr;
  logic                           div_busy, div_done;
  logic [liu2x_pkg::QUOT_W-1:0]   div_quot;
  logic [liu2x_pkg::LEN_W-1:0]    eff_n;
  logic [liu2x_pkg::OCNT_W-1:0]   last_out;
  logic [liu2x_pkg::LEN_W-1:0]    frac;
  logic [liu2x_pkg::LEN_W:0]      due;
  logic signed [16:0]             diff;
  logic signed [33:0]             prod;
  logic [liu2x_pkg::SAMPLE_W-1:0] blend;
  logic                           out_load;

  assign len_wr = cfg_valid_i && (cfg_index_i == liu2x_pkg::REG_BLOCK_LENGTH);

  liu2x_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (len_wr),
    .len_i   (liu2x_pkg::eff_len(cfg_data_i[liu2x_pkg::LEN_W-1:0])),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign eff_n    = liu2x_pkg::eff_len(blen_q);
  assign last_out = {eff_n, 1'b0} - 17'd2;
  assign frac     = phase_q[15:0];
  assign due      = {1'b0, phase_q[31:16]} + {16'd0, (frac != 16'd0)};

  assign diff  = $signed({cur_q[15], cur_q}) - $signed({prev_q[15], prev_q});
  assign prod  = diff * $signed({1'b0, frac});
  assign blend = prev_q + prod[31:16];

  assign out_load = cmd_i.emit || cmd_i.emit_last;

  assign sts_o.bypass   = (src_q == tgt_q);
  assign sts_o.more     = (out_cnt_q <= last_out) && (due == {1'b0, in_cnt_q});
  assign sts_o.at_last  = (in_cnt_q >= (eff_n - 16'd1));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.div_busy = div_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q      <= liu2x_pkg::BLOCK_LENGTH_RST;
      src_q       <= liu2x_pkg::SOURCE_RATE_RST;
      tgt_q       <= liu2x_pkg::TARGET_RATE_RST;
      step_q      <= liu2x_pkg::STEP_RST;
      phase_q     <= '0;
      in_cnt_q    <= '0;
      out_cnt_q   <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          liu2x_pkg::REG_BLOCK_LENGTH: blen_q <= cfg_data_i[liu2x_pkg::LEN_W-1:0];
          liu2x_pkg::REG_SOURCE_RATE:  src_q  <= cfg_data_i;
          liu2x_pkg::REG_TARGET_RATE:  tgt_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (div_done) begin
        step_q <= {1'b0, div_quot};
      end
      if (len_wr || cmd_i.restart) begin
        phase_q   <= '0;
        in_cnt_q  <= '0;
        out_cnt_q <= '0;
        prev_q    <= '0;
      end else begin
        if (cmd_i.emit) begin
          phase_q   <= phase_q + {15'd0, step_q};
          out_cnt_q <= out_cnt_q + 17'd1;
        end
        if (cmd_i.advance) begin
          prev_q   <= cur_q;
          in_cnt_q <= in_cnt_q + 16'd1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cur) begin
      cur_q <= in_sample_i;
    end
    if (out_load) begin
      out_sample_q <= (cmd_i.emit_last || frac == 16'd0) ? cur_q : blend;
      block_end_q  <= cmd_i.emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign block_end_o  = block_end_q;

endmodule

// ===== hdl/liu2x_ctrl.sv =====
// Controller: takes one input word at a time and sequences the outputs it releases.
module liu2x_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  liu2x_pkg::sts_t  sts_i,
  output logic             in_stall_o,
  output liu2x_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_LAST
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic       room;

  assign room       = (cnt_q != 2'd3);
  assign in_stall_o = (state_q != ST_IDLE) || sts_i.div_busy;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !sts_i.div_busy && !sts_i.bypass) begin
          cmd_o.load_cur = 1'b1;
          cnt_d          = 2'd0;
          state_d        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.more && room) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            cnt_d      = cnt_q + 2'd1;
          end
        end else if (sts_i.at_last) begin
          if (room) begin
            state_d = ST_LAST;
          end else begin
            cmd_o.restart = 1'b1;
            state_d       = ST_IDLE;
          end
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_LAST: begin
        if (sts_i.out_free) begin
          cmd_o.emit_last = 1'b1;
          cmd_o.restart   = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hdl/linear_interp_upsampler_2x.sv =====
// Top level of the two-times linear-interpolation upsampler.
// Each input word is taken, then releases up to three outputs, one per cycle
// through the output register while the output is not stalled; the item is
// then closed, and the block's last word adds its final copied sample when
// fewer than three outputs were released. After a write to block_length the
// 16.16 step is recomputed by a bit-serial divider, during which input is
// stalled. Configuration is always ready; source and target rates equal
// means input words are consumed with no output.
module linear_interp_upsampler_2x (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [liu2x_pkg::SAMPLE_W-1:0]  in_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [liu2x_pkg::SAMPLE_W-1:0]  out_sample_o,
  output logic                            block_end_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [liu2x_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [liu2x_pkg::RATE_W-1:0]    cfg_data_i
);

  liu2x_pkg::cmd_t cmd;
  liu2x_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  liu2x_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  liu2x_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_sample_i  (in_sample_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_sample_o (out_sample_o),
    .block_end_o  (block_end_o)
  );

endmodule

// ===== hdl/liu2x_chk.sv =====
// Port-level checker for the upsampler, bound to its top level.
module liu2x_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [liu2x_pkg::SAMPLE_W-1:0]  out_sample_o,
  input logic                            block_end_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [liu2x_pkg::IDX_W-1:0]     cfg_index_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output word dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_sample_o) && $stable(block_end_o))
    else $error("Stalled output word changed.");

  a_len_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i == liu2x_pkg::REG_BLOCK_LENGTH)
    |=> in_stall_o)
    else $error("Input not stalled while the step is recomputed.");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Output word appeared without an input word in progress.");

endmodule

bind linear_interp_upsampler_2x liu2x_chk u_chk (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the two-times linear-interpolation upsampler.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [liu2x_pkg::IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int ITEMS = 300;
  localparam int SETTLE = 12;
  localparam int WATCHDOG = 3000;

  typedef struct packed {
    logic [liu2x_pkg::SAMPLE_W-1:0] sample;
    logic                           last;
  } up_word_t;

  class interp_scoreboard;
    logic [liu2x_pkg::LEN_W-1:0]    blk_len;
    logic [liu2x_pkg::RATE_W-1:0]   src_rate;
    logic [liu2x_pkg::RATE_W-1:0]   dst_rate;
    logic [liu2x_pkg::SAMPLE_W-1:0] prev_in;
    logic [liu2x_pkg::PHASE_W-1:0]  phase;
    logic [liu2x_pkg::STEP_W-1:0]   step;
    logic [liu2x_pkg::LEN_W-1:0]    in_cnt;
    logic [liu2x_pkg::OCNT_W-1:0]   out_cnt;
    up_word_t                       due_q[$];
    int                             n_err;

    function new();
      blk_len = liu2x_pkg::BLOCK_LENGTH_RST;
      src_rate = liu2x_pkg::SOURCE_RATE_RST;
      dst_rate = liu2x_pkg::TARGET_RATE_RST;
      n_err = 0;
      load_step();
      restart();
    endfunction

    function int unsigned eff_n();
      int unsigned n;
      n = blk_len;
      if (n < liu2x_pkg::MIN_BLOCK) begin
        n = liu2x_pkg::MIN_BLOCK;
      end
      if (n > liu2x_pkg::MAX_BLOCK) begin
        n = liu2x_pkg::MAX_BLOCK;
      end
      return n;
    endfunction

    function void load_step();
      int unsigned n;
      logic [63:0] num;
      n = eff_n();
      num = 64'(n - 2) << 16;
      step = liu2x_pkg::STEP_W'(num / 64'(2 * n - 2));
    endfunction

    function void restart();
      prev_in = '0;
      phase = '0;
      in_cnt = '0;
      out_cnt = '0;
    endfunction

    function bit bypass();
      return src_rate == dst_rate;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void write_reg(input logic [liu2x_pkg::IDX_W-1:0] idx,
                            input logic [liu2x_pkg::RATE_W-1:0] data);
      case (idx)
        liu2x_pkg::REG_BLOCK_LENGTH: begin
          blk_len = data[liu2x_pkg::LEN_W-1:0];
          load_step();
          restart();
        end
        liu2x_pkg::REG_SOURCE_RATE: begin
          src_rate = data;
        end
        liu2x_pkg::REG_TARGET_RATE: begin
          dst_rate = data;
        end
        default: begin
        end
      endcase
    endfunction

    // Floor of the weighted blend of two neighbouring samples over 0x10000.
    function logic [liu2x_pkg::SAMPLE_W-1:0] mix(
        input logic signed [liu2x_pkg::SAMPLE_W-1:0] a,
        input logic signed [liu2x_pkg::SAMPLE_W-1:0] b,
        input logic [15:0] t);
      longint acc;
      acc = longint'(a) * (longint'(65536) - longint'(t)) + longint'(b) * longint'(t);
      return liu2x_pkg::SAMPLE_W'(acc >>> 16);
    endfunction

    function void take_sample(input logic [liu2x_pkg::SAMPLE_W-1:0] s);
      int unsigned n;
      int unsigned last_out;
      int unsigned idx;
      int unsigned due;
      int unsigned cnt;
      logic [15:0] t;
      up_word_t    w;
      if (bypass()) begin
        return;
      end
      n = eff_n();
      last_out = 2 * n - 2;
      cnt = 0;
      while (cnt < 3 && out_cnt <= last_out) begin
        idx = phase[31:16];
        t = phase[15:0];
        due = idx + ((t != 0) ? 1 : 0);
        if (due != in_cnt) begin
          break;
        end
        w.sample = (t == 0) ? s : mix(prev_in, s, t);
        w.last = 1'b0;
        due_q = {due_q, w};
        cnt++;
        phase += liu2x_pkg::PHASE_W'(step);
        out_cnt++;
      end
      if (in_cnt >= n - 1) begin
        if (cnt < 3) begin
          w.sample = s;
          w.last = 1'b1;
          due_q = {due_q, w};
        end
        restart();
      end else begin
        prev_in = s;
        in_cnt++;
      end
    endfunction

    function void check_output(input logic [liu2x_pkg::SAMPLE_W-1:0] s, input logic last);
      up_word_t w;
      if (due_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) begin
          $display("unexpected output word: sample %h block_end %b", s, last);
        end
        return;
      end
      w = due_q.pop_front();
      if (w.sample !== s || w.last !== last) begin
        n_err++;
        if (n_err <= 10) begin
          $display("output mismatch: expected sample %h block_end %b, got sample %h block_end %b",
                   w.sample, w.last, s, last);
        end
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [liu2x_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [liu2x_pkg::SAMPLE_W-1:0] out_sample;
  logic                           block_end;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [liu2x_pkg::IDX_W-1:0]    cfg_index = '0;
  logic [liu2x_pkg::RATE_W-1:0]   cfg_data = '0;

  interp_scoreboard sb = new();
  bit idle_on = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit seen;
  int items_sent = 0;

  linear_interp_upsampler_2x u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_sample_i  (in_sample),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_sample_o (out_sample),
    .block_end_o  (block_end),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      seen = 1'b0;
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        seen = 1'b1;
      end
      if (in_valid && !in_stall) begin
        sb.take_sample(in_sample);
        seen = 1'b1;
      end
      if (out_valid && !out_stall) begin
        sb.check_output(out_sample, block_end);
        seen = 1'b1;
      end
      idle_cycles = seen ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("linear_interp_upsampler_2x test failed");
        $finish;
      end
    end
  end

  function automatic logic [liu2x_pkg::SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'h7fff;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    return liu2x_pkg::SAMPLE_W'($urandom);
  endfunction

  function automatic logic [liu2x_pkg::RATE_W-1:0] pick_rate();
    if ($urandom_range(0, 1) == 1) begin
      return liu2x_pkg::RATE_W'($urandom_range(0, 131071));
    end
    case ($urandom_range(0, 3))
      0: return 17'd8000;
      1: return 17'd44100;
      2: return 17'd48000;
      default: return 17'd96000;
    endcase
  endfunction

  task automatic set_reg(input logic [liu2x_pkg::IDX_W-1:0] idx,
                         input logic [liu2x_pkg::RATE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(input logic [liu2x_pkg::SAMPLE_W-1:0] s);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
  endtask

  // The sender holds off until every expected word has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int unsigned n;
    int unsigned cnt;
    logic [liu2x_pkg::RATE_W-1:0] ra;
    logic [liu2x_pkg::RATE_W-1:0] rb;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;

    set_reg(liu2x_pkg::REG_BLOCK_LENGTH, 17'd4);
    send_word(16'h7fff);
    send_word(16'h8000);
    send_word(16'h0000);
    send_word(16'hffff);
    send_word(16'h8000);
    send_word(16'h7fff);
    send_word(16'h8000);
    send_word(16'h7fff);
    drain();
    set_reg(liu2x_pkg::REG_BLOCK_LENGTH, 17'd0);
    send_word(16'h0001);
    send_word(16'hfffe);
    send_word(16'h4000);
    send_word(16'hc000);
    drain();
    set_reg(liu2x_pkg::REG_BLOCK_LENGTH, 17'h10005);
    send_word(16'h1234);
    send_word(16'hedcb);
    drain();
    set_reg(liu2x_pkg::REG_BLOCK_LENGTH, 17'd3);
    repeat (4) send_word(pick_sample());
    drain();
    set_reg(liu2x_pkg::REG_BLOCK_LENGTH, 17'hffff);
    repeat (2) send_word(pick_sample());
    drain();
    set_reg(liu2x_pkg::REG_BLOCK_LENGTH, 17'd32768);
    repeat (2) send_word(pick_sample());
    drain();
    set_reg(liu2x_pkg::REG_SOURCE_RATE, 17'd96000);
    set_reg(liu2x_pkg::REG_TARGET_RATE, 17'd96000);
    repeat (2) send_word(pick_sample());
    drain();
    set_reg(liu2x_pkg::REG_SOURCE_RATE, 17'd0);
    set_reg(liu2x_pkg::REG_TARGET_RATE, 17'd0);
    send_word(16'h5555);
    drain();
    set_reg(liu2x_pkg::REG_TARGET_RATE, 17'h1ffff);
    set_reg(REG_SPARE, 17'h1ffff);
    repeat (2) send_word(pick_sample());

    while (items_sent < ITEMS) begin
      drain();
      idle_on = (items_sent < ITEMS - 60) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        ra = pick_rate();
        set_reg(liu2x_pkg::REG_SOURCE_RATE, ra);
        set_reg(liu2x_pkg::REG_TARGET_RATE, ra);
        repeat ($urandom_range(1, 6)) send_word(pick_sample());
      end else begin
        if ($urandom_range(0, 9) < 7) begin
          case ($urandom_range(0, 19))
            0: set_reg(liu2x_pkg::REG_BLOCK_LENGTH,
                       liu2x_pkg::RATE_W'($urandom_range(0, 3)));
            1: set_reg(liu2x_pkg::REG_BLOCK_LENGTH, liu2x_pkg::RATE_W'($urandom));
            2: set_reg(liu2x_pkg::REG_BLOCK_LENGTH,
                       liu2x_pkg::RATE_W'(32768 + $urandom_range(0, 32767)));
            default: set_reg(liu2x_pkg::REG_BLOCK_LENGTH,
                             liu2x_pkg::RATE_W'($urandom_range(4, 24)));
          endcase
        end
        if (sb.bypass() || $urandom_range(0, 2) == 0) begin
          do begin
            ra = pick_rate();
            rb = pick_rate();
          end while (ra == rb);
          set_reg(liu2x_pkg::REG_SOURCE_RATE, ra);
          set_reg(liu2x_pkg::REG_TARGET_RATE, rb);
        end
        n = sb.eff_n();
        if (n > 64) begin
          cnt = $urandom_range(4, 24);
        end else begin
          cnt = n * $urandom_range(1, 3);
          if ($urandom_range(0, 3) == 0) begin
            cnt += $urandom_range(1, n - 1);
          end
        end
        repeat (cnt) send_word(pick_sample());
        items_sent += cnt;
      end
    end

    drain();
    if (sb.n_err == 0 && sb.pending() == 0) begin
      $display("linear_interp_upsampler_2x test passed");
    end else begin
      $display("linear_interp_upsampler_2x test failed");
    end
    $finish;
  end

endmodule
